>>> sv/dnsrap_pkg.sv
package dnsrap_pkg;

  // Payload widths of the three channels.
  localparam int InWidth  = 9;
  localparam int OutWidth = 34;
  localparam int CfgWidth = 16;

  // Record fields that select an IPv4 host address.
  localparam logic [15:0] TypeA   = 16'd1;
  localparam logic [15:0] ClassIn = 16'd1;
  localparam logic [15:0] AddrLen = 16'd4;

  // Outcome reported once per datagram.
  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_ID_MISMATCH = 2'd1,
    ST_NO_ADDRESS  = 2'd2,
    ST_TRUNCATED   = 2'd3
  } status_e;

  typedef struct packed {
    logic       end_of_datagram;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
  } out_item_t;

endpackage

>>> sv/dnsrap_stream_if.sv
interface dnsrap_stream_if #(
  parameter int Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/dns_response_address_parser.sv
// Parses a DNS response one byte per cycle: a new byte is taken in every cycle
// while the skid register is empty, and the state machine handles each byte in
// the cycle it is accepted. A datagram's status item is registered into the
// output register (or the skid register while that is held) from the byte
// that decides it: the second id byte, the fourth address byte, the end of the
// last record or header/question, or the end-marked byte if nothing was decided.
// The two-entry output buffer (output register plus skid register) lets input
// bytes flow while a status item waits; input ready drops only when both are full.
// The expected transaction id may be written whenever the parser is idle.
module dns_response_address_parser import dnsrap_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  dnsrap_stream_if.sink   cfg_i,
  dnsrap_stream_if.sink   in_i,
  dnsrap_stream_if.source out_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_QLEN,
    PH_QLABEL,
    PH_QTAIL,
    PH_RFIXED,
    PH_RADDR,
    PH_RSKIP,
    PH_IGNORE
  } phase_e;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [3:0]  bpos_q, bpos_d;
  logic [7:0]  id_hi_q, id_hi_d;
  logic [15:0] quest_q, quest_d;
  logic [17:0] rec_q, rec_d;
  logic [7:0]  label_q, label_d;
  logic [15:0] rtype_q, rtype_d;
  logic [15:0] rclass_q, rclass_d;
  logic [15:0] rdata_q, rdata_d;
  logic [31:0] addr_q, addr_d;

  logic [15:0] exp_id_q;

  // Output buffer.
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;

  in_item_t  in_item;
  logic      acc;
  logic      push;
  status_e   res_status;
  out_item_t res;
  logic [3:0]  bpos_inc;
  logic [15:0] rdata_full;
  logic [17:0] rec_next;

  assign in_item  = in_item_t'(in_i.data);
  assign acc      = in_i.valid && in_i.ready;
  assign bpos_inc = bpos_q + 4'd1;
  assign rdata_full = {rdata_q[15:8], in_item.data_byte};
  assign rec_next = rec_q - 18'd1;

  // Configuration register is always ready.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= '0;
    end else if (cfg_i.valid) begin
      exp_id_q <= cfg_i.data[15:0];
    end
  end

  // Per-byte next state and decision.
  always_comb begin
    phase_d    = phase_q;
    bpos_d     = bpos_q;
    id_hi_d    = id_hi_q;
    quest_d    = quest_q;
    rec_d      = rec_q;
    label_d    = label_q;
    rtype_d    = rtype_q;
    rclass_d   = rclass_q;
    rdata_d    = rdata_q;
    addr_d     = addr_q;
    push       = 1'b0;
    res_status = ST_FOUND;

    case (phase_q)
      PH_HEADER: begin
        bpos_d = bpos_inc;
        case (bpos_q)
          4'd0: id_hi_d = in_item.data_byte;
          4'd1: begin
            if ({id_hi_q, in_item.data_byte} != exp_id_q) begin
              push       = 1'b1;
              res_status = ST_ID_MISMATCH;
              phase_d    = PH_IGNORE;
            end
          end
          4'd4: quest_d = {in_item.data_byte, 8'h00};
          4'd5: quest_d = {quest_q[15:8], in_item.data_byte};
          4'd6, 4'd8, 4'd10: rdata_d = {in_item.data_byte, 8'h00};
          4'd7, 4'd9, 4'd11: begin
            rec_d   = rec_q + {2'b00, rdata_full};
            rdata_d = '0;
            if (bpos_q == 4'd11) begin
              bpos_d = '0;
              if (quest_q != '0) begin
                phase_d = PH_QLEN;
              end else if (rec_d == '0) begin
                push       = 1'b1;
                res_status = ST_NO_ADDRESS;
                phase_d    = PH_IGNORE;
              end else begin
                phase_d = PH_RFIXED;
              end
            end
          end
          default: ;
        endcase
      end

      PH_QLEN: begin
        if (in_item.data_byte == 8'd0) begin
          phase_d = PH_QTAIL;
          bpos_d  = '0;
        end else begin
          label_d = in_item.data_byte;
          phase_d = PH_QLABEL;
        end
      end

      PH_QLABEL: begin
        label_d = label_q - 8'd1;
        if (label_d == '0) begin
          phase_d = PH_QLEN;
        end
      end

      PH_QTAIL: begin
        bpos_d = bpos_inc;
        if (bpos_inc == 4'd4) begin
          bpos_d  = '0;
          quest_d = quest_q - 16'd1;
          if (quest_d != '0) begin
            phase_d = PH_QLEN;
          end else if (rec_q == '0) begin
            push       = 1'b1;
            res_status = ST_NO_ADDRESS;
            phase_d    = PH_IGNORE;
          end else begin
            phase_d = PH_RFIXED;
          end
        end
      end

      PH_RFIXED: begin
        bpos_d = bpos_inc;
        case (bpos_q)
          4'd2:  rtype_d  = {in_item.data_byte, 8'h00};
          4'd3:  rtype_d  = {rtype_q[15:8], in_item.data_byte};
          4'd4:  rclass_d = {in_item.data_byte, 8'h00};
          4'd5:  rclass_d = {rclass_q[15:8], in_item.data_byte};
          4'd10: rdata_d  = {in_item.data_byte, 8'h00};
          4'd11: begin
            rdata_d = rdata_full;
            bpos_d  = '0;
            if (rtype_q == TypeA && rclass_q == ClassIn && rdata_full == AddrLen) begin
              phase_d = PH_RADDR;
              addr_d  = '0;
            end else if (rdata_full == '0) begin
              rec_d = rec_next;
              if (rec_next == '0) begin
                push       = 1'b1;
                res_status = ST_NO_ADDRESS;
                phase_d    = PH_IGNORE;
              end else begin
                phase_d = PH_RFIXED;
              end
            end else begin
              phase_d = PH_RSKIP;
            end
          end
          default: ;
        endcase
      end

      PH_RADDR: begin
        addr_d = {addr_q[23:0], in_item.data_byte};
        bpos_d = bpos_inc;
        if (bpos_inc == AddrLen[3:0]) begin
          push       = 1'b1;
          res_status = ST_FOUND;
          phase_d    = PH_IGNORE;
        end
      end

      PH_RSKIP: begin
        rdata_d = rdata_q - 16'd1;
        if (rdata_d == '0) begin
          rec_d  = rec_next;
          bpos_d = '0;
          if (rec_next == '0) begin
            push       = 1'b1;
            res_status = ST_NO_ADDRESS;
            phase_d    = PH_IGNORE;
          end else begin
            phase_d = PH_RFIXED;
          end
        end
      end

      default: begin
        phase_d = PH_IGNORE;
      end
    endcase

    // Already decided: bytes are dropped until the end mark.
    if (phase_q == PH_IGNORE) begin
      push = 1'b0;
    end

    // End mark before any decision reports truncation.
    if (in_item.end_of_datagram && phase_q != PH_IGNORE && !push) begin
      push       = 1'b1;
      res_status = ST_TRUNCATED;
    end

    // The end mark always returns the parser to its start.
    if (in_item.end_of_datagram) begin
      phase_d  = PH_HEADER;
      bpos_d   = '0;
      id_hi_d  = '0;
      quest_d  = '0;
      rec_d    = '0;
      label_d  = '0;
      rtype_d  = '0;
      rclass_d = '0;
      rdata_d  = '0;
    end
  end

  assign res.status  = res_status;
  assign res.address = (res_status == ST_FOUND) ? addr_d : 32'd0;

  // State registers advance on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      bpos_q   <= '0;
      id_hi_q  <= '0;
      quest_q  <= '0;
      rec_q    <= '0;
      label_q  <= '0;
      rtype_q  <= '0;
      rclass_q <= '0;
      rdata_q  <= '0;
      addr_q   <= '0;
    end else if (acc) begin
      phase_q  <= phase_d;
      bpos_q   <= bpos_d;
      id_hi_q  <= id_hi_d;
      quest_q  <= quest_d;
      rec_q    <= rec_d;
      label_q  <= label_d;
      rtype_q  <= rtype_d;
      rclass_q <= rclass_d;
      rdata_q  <= rdata_d;
      addr_q   <= addr_d;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_o.ready) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= acc && push;
        end else begin
          out_valid_q <= acc && push;
        end
      end else if (acc && push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (acc && push) begin
          skid_q <= res;
        end
      end else if (acc && push) begin
        out_q <= res;
      end
    end else if (acc && push) begin
      skid_q <= res;
    end
  end

  assign in_i.ready  = !skid_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // The skid entry is only used behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds an item while the output register is empty");

  // Only a found status carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_FOUND) |-> (out_q.address == 32'd0))
    else $error("address is nonzero on a status other than found");

  // An end mark returns the parser to the header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_item.end_of_datagram) |=> (phase_q == PH_HEADER && bpos_q == 4'd0))
    else $error("parser did not restart after the end mark");

  // An undecided datagram always reports on its end mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_item.end_of_datagram && phase_q != PH_IGNORE) |-> push)
    else $error("end mark without a decision produced no status");

  // A decided datagram produces nothing more until its end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IGNORE) |-> !push)
    else $error("status produced after the datagram was decided");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dnsrap_pkg::*;

  // A stretch of this many cycles with no item moving on any channel ends the run.
  localparam int StallLimit = 4000;
  localparam int HoldOffCycles = 700;
  localparam int PhaseBytes = 280;
  localparam int PhaseDatagrams = 4;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    P_HEADER,
    P_QLEN,
    P_QLABEL,
    P_QTAIL,
    P_RFIXED,
    P_RADDR,
    P_RSKIP,
    P_IGNORE
  } parse_phase_e;

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_NO_RESULT,
    ROW_RESULT
  } row_check_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_datagram;
    row_check_e  check;
    status_e     status;
    logic [31:0] address;
  } row_t;

  logic clk_i;
  logic rst_ni;

  dnsrap_stream_if #(.Width(CfgWidth)) cfg_if ();
  dnsrap_stream_if #(.Width(InWidth))  in_if ();
  dnsrap_stream_if #(.Width(OutWidth)) out_if ();

  dns_response_address_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: a copy of the parser and of the transaction id register.
  parse_phase_e st_phase;
  logic [3:0]   st_pos;
  logic [7:0]   id_hi;
  logic [15:0]  q_left;
  logic [17:0]  rec_left;
  logic [7:0]   lab_left;
  logic [15:0]  rec_type;
  logic [15:0]  rec_class;
  logic [15:0]  rd_left;
  logic [31:0]  addr_acc;
  logic         decided;
  status_e      verdict;
  logic [15:0]  cur_id;

  out_item_t    awaited_status[$];
  int           errors;
  int           bytes_accepted;
  bit           table_mode;
  row_t         table_row;
  int           burst_left;
  logic [7:0]   dgram[$];

  // Directed datagrams: early end, id mismatch on the end-marked byte, a header
  // with no records followed by an ignored byte, and a huge record count cut short.
  row_t directed_rows [29] = '{
    '{8'hFF, 1'b1, ROW_RESULT, ST_TRUNCATED, 32'h0},
    '{8'hFF, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'hFF, 1'b1, ROW_RESULT, ST_ID_MISMATCH, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h81, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h80, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_RESULT, ST_NO_ADDRESS, 32'h0},
    '{8'hAB, 1'b1, ROW_NO_RESULT, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'hFF, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'hFF, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b0, ROW_PREDICTED, ST_FOUND, 32'h0},
    '{8'h00, 1'b1, ROW_RESULT, ST_TRUNCATED, 32'h0}
  };

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Returns the parser to the state it has after reset; the id register stays.
  function automatic void clear_parser();
    st_phase  = P_HEADER;
    st_pos    = '0;
    id_hi     = '0;
    q_left    = '0;
    rec_left  = '0;
    lab_left  = '0;
    rec_type  = '0;
    rec_class = '0;
    rd_left   = '0;
    addr_acc  = '0;
    decided   = 1'b0;
  endfunction

  function automatic bit conclude(status_e code);
    verdict  = code;
    decided  = 1'b1;
    st_phase = P_IGNORE;
    return 1'b1;
  endfunction

  // Enters the record walk, or reports no address when no record is left.
  function automatic bit enter_records();
    if (rec_left == 0) begin
      return conclude(ST_NO_ADDRESS);
    end
    st_phase = P_RFIXED;
    st_pos   = '0;
    return 1'b0;
  endfunction

  function automatic bit advance_record();
    rec_left = rec_left - 18'd1;
    return enter_records();
  endfunction

  // Moves the parser by one payload byte; returns 1 when the byte decides.
  function automatic bit parse_byte(logic [7:0] b);
    logic [3:0] p;
    p = st_pos;
    case (st_phase)
      P_HEADER: begin
        st_pos = st_pos + 4'd1;
        case (p)
          4'd0: id_hi = b;
          4'd1: begin
            if ({id_hi, b} != cur_id) begin
              return conclude(ST_ID_MISMATCH);
            end
          end
          4'd4: q_left = {b, 8'h00};
          4'd5: q_left[7:0] = b;
          4'd6, 4'd8, 4'd10: rd_left = {b, 8'h00};
          4'd7, 4'd9, 4'd11: begin
            rec_left = rec_left + 18'({rd_left[15:8], b});
            rd_left  = '0;
            if (p == 4'd11) begin
              st_pos = '0;
              if (q_left != 0) begin
                st_phase = P_QLEN;
                return 1'b0;
              end
              return enter_records();
            end
          end
          default: ;
        endcase
      end
      P_QLEN: begin
        if (b == 8'h00) begin
          st_phase = P_QTAIL;
          st_pos   = '0;
        end else begin
          lab_left = b;
          st_phase = P_QLABEL;
        end
      end
      P_QLABEL: begin
        lab_left = lab_left - 8'd1;
        if (lab_left == 0) begin
          st_phase = P_QLEN;
        end
      end
      P_QTAIL: begin
        st_pos = st_pos + 4'd1;
        if (st_pos == 4'd4) begin
          st_pos = '0;
          q_left = q_left - 16'd1;
          if (q_left == 0) begin
            return enter_records();
          end
          st_phase = P_QLEN;
        end
      end
      P_RFIXED: begin
        st_pos = st_pos + 4'd1;
        case (p)
          4'd2: rec_type = {b, 8'h00};
          4'd3: rec_type[7:0] = b;
          4'd4: rec_class = {b, 8'h00};
          4'd5: rec_class[7:0] = b;
          4'd10: rd_left = {b, 8'h00};
          4'd11: begin
            rd_left[7:0] = b;
            st_pos = '0;
            if (rec_type == TypeA && rec_class == ClassIn && rd_left == AddrLen) begin
              st_phase = P_RADDR;
              addr_acc = '0;
              return 1'b0;
            end
            if (rd_left == 0) begin
              return advance_record();
            end
            st_phase = P_RSKIP;
          end
          default: ;
        endcase
      end
      P_RADDR: begin
        addr_acc = {addr_acc[23:0], b};
        st_pos   = st_pos + 4'd1;
        if (st_pos == 4'd4) begin
          return conclude(ST_FOUND);
        end
      end
      P_RSKIP: begin
        rd_left = rd_left - 16'd1;
        if (rd_left == 0) begin
          return advance_record();
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Works out the status item, if any, that one accepted byte causes.
  function automatic bit predict_status(in_item_t it, output out_item_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    if (!decided) begin
      hit = parse_byte(it.data_byte);
    end
    if (it.end_of_datagram && !decided) begin
      verdict = ST_TRUNCATED;
      hit = 1'b1;
    end
    if (hit) begin
      res.status  = verdict;
      res.address = (verdict == ST_FOUND) ? addr_acc : 32'h0;
    end
    if (it.end_of_datagram) begin
      clear_parser();
    end
    return hit;
  endfunction

  // Follows all three channels at the rising edge: checks results, predicts new ones.
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    out_item_t pred;
    bit        hit;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        cur_id = cfg_if.data;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (awaited_status.size() == 0) begin
          $error("unexpected status item: status %0d address %h", got.status, got.address);
          errors++;
        end else begin
          want = awaited_status.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.address !== want.address) begin
            $error("address: expected %h, actual %h", want.address, got.address);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        bytes_accepted++;
        hit = predict_status(in_item_t'(in_if.data), pred);
        if (table_mode && table_row.check != ROW_PREDICTED) begin
          if (table_row.check == ROW_RESULT) begin
            want.status  = table_row.status;
            want.address = table_row.address;
            awaited_status.push_back(want);
          end
        end else if (hit) begin
          awaited_status.push_back(pred);
        end
      end
    end
  end

  // Result side: stall patterns that change at random, plus two long hold-offs.
  initial begin
    int mode;
    int left;
    int holdoffs;
    out_if.ready = 1'b0;
    mode = 0;
    left = 0;
    holdoffs = 0;
    forever begin
      @(negedge clk_i);
      if (holdoffs < 2 && bytes_accepted >= ((holdoffs == 0) ? 300 : 1100)) begin
        holdoffs++;
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one byte in bursts with random gaps; entered and left at a falling edge.
  task automatic send_byte(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_expected_id(logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Stops offering bytes and waits until every awaited status item has come out.
  task automatic drain_results(int extra);
    in_if.valid <= 1'b0;
    while (awaited_status.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic push_word(logic [15:0] value);
    dgram.push_back(value[15:8]);
    dgram.push_back(value[7:0]);
  endtask

  task automatic push_random(int count);
    repeat (count) dgram.push_back(8'($urandom_range(0, 255)));
  endtask

  // Builds one datagram: mostly well formed with random content, some with a wrong
  // id, a huge record count, a cut-off end, or plain noise.
  task automatic build_datagram();
    int          kind;
    int          qd;
    int          an;
    int          ns;
    int          ar;
    int          total;
    int          len;
    int          cut;
    logic [15:0] id;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rdlen;
    dgram.delete();
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      push_random($urandom_range(1, 24));
    end else begin
      id = cur_id;
      if (kind < 12) begin
        id = id ^ 16'($urandom_range(1, 65535));
      end
      push_word(id);
      push_random(2);
      qd = $urandom_range(0, 2);
      an = $urandom_range(0, 2);
      ns = $urandom_range(0, 1);
      ar = $urandom_range(0, 1);
      if (kind < 16) begin
        an = $urandom_range(0, 65535);
      end
      push_word(16'(qd));
      push_word(16'(an));
      push_word(16'(ns));
      push_word(16'(ar));
      repeat (qd) begin
        repeat ($urandom_range(0, 2)) begin
          len = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(1, 5);
          dgram.push_back(8'(len));
          push_random(len);
        end
        dgram.push_back(8'h00);
        push_random(4);
      end
      total = an + ns + ar;
      if (total > 6) begin
        total = 6;
      end
      repeat (total) begin
        push_word(16'hC00C);
        rtype  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : TypeA;
        rclass = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : ClassIn;
        if (rtype == TypeA && rclass == ClassIn) begin
          rdlen = ($urandom_range(0, 3) != 0) ? AddrLen : 16'($urandom_range(0, 8));
        end else begin
          rdlen = 16'($urandom_range(0, 6));
        end
        push_word(rtype);
        push_word(rclass);
        push_random(4);
        push_word(rdlen);
        push_random(rdlen);
      end
      push_random($urandom_range(0, 2));
      if (kind >= 88) begin
        cut = $urandom_range(1, dgram.size());
        while (dgram.size() > cut) void'(dgram.pop_back());
      end
    end
  endtask

  // Reset, directed table, then random phases under different transaction ids.
  initial begin
    logic [15:0] phase_ids [5];
    int          phase_bytes;
    int          phase_dgrams;
    in_item_t    it;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    errors       = 0;
    bytes_accepted = 0;
    burst_left   = 0;
    table_mode   = 1'b1;
    cur_id       = '0;
    clear_parser();
    phase_ids = '{16'hFFFF, 16'($urandom_range(0, 65535)), 16'h0000,
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      table_row = directed_rows[i];
      it.data_byte       = directed_rows[i].data_byte;
      it.end_of_datagram = directed_rows[i].end_of_datagram;
      send_byte(it);
    end
    table_mode = 1'b0;

    foreach (phase_ids[k]) begin
      drain_results(4);
      write_expected_id(phase_ids[k]);
      phase_bytes  = 0;
      phase_dgrams = 0;
      while (phase_bytes < PhaseBytes || phase_dgrams < PhaseDatagrams) begin
        build_datagram();
        foreach (dgram[i]) begin
          it.data_byte       = dgram[i];
          it.end_of_datagram = (i == dgram.size() - 1);
          send_byte(it);
        end
        phase_bytes += dgram.size();
        phase_dgrams++;
      end
    end

    drain_results(10);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
